// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the PWM timer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PWMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pwmt assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PWMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pwmt assertion failed");

`endif

// ===== design/pwmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmt_pkg
// Constants, register map and control bundle of the two-channel PWM timer.
// ----------------------------------------------------------------------------
package pwmt_pkg;

	// Clocking of the timer
	localparam int unsigned CPU_HZ   = 16000000;
	localparam int unsigned PRESCALE = 8;
	localparam logic [2:0]  PS_LAST  = 3'(PRESCALE - 1);

	// Dividend of the period division
	localparam int unsigned DIV_N = CPU_HZ / PRESCALE;
	localparam int NW = $clog2(DIV_N + 1);
	// Product duty * (top + 1): 10 by 17 bits
	localparam int PW = 27;
	// Period divider width and its step counter
	localparam int DW = NW;
	localparam int CW = $clog2(DW + 1);

	// Reset configuration and the period end derived from it
	localparam logic [15:0] RST_FREQ = 16'd1000;
	localparam int unsigned RST_Q0 = DIV_N / 1000;
	localparam int unsigned RST_Q1 = (RST_Q0 == 0) ? 1 : RST_Q0;
	localparam int unsigned RST_QM = RST_Q1 - 1;
	localparam logic [15:0] RST_TOP = 16'((RST_QM > 65535) ? 65535 : RST_QM);

	// Duty scaling
	localparam logic [9:0]  DUTY_MAX = 10'd1000;
	localparam logic [15:0] DUTY_DIV = 16'd1000;

	// Divide by one thousand as a reciprocal multiply; the product stays
	// below 2^26, so the rounded-up reciprocal with a 36-bit shift is exact
	localparam int RCP_SH = 36;
	localparam longint unsigned RCP_DEN  = 64'(DUTY_DIV);
	localparam longint unsigned RCP_LONG = ((64'd1 << RCP_SH) + RCP_DEN - 64'd1) / RCP_DEN;
	localparam logic [26:0] RCP_1000 = 27'(RCP_LONG);
	localparam int SW = PW + 27;

	// Register map (word index = paddr[4:2])
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_FREQ   = 3'd0;
	localparam logic [2:0] REG_DUTY_A = 3'd1;
	localparam logic [2:0] REG_DUTY_B = 3'd2;
	localparam logic [2:0] REG_EN_A   = 3'd3;
	localparam logic [2:0] REG_EN_B   = 3'd4;

	// Control from the register block to the counter core
	typedef struct packed {
		logic        busy;
		logic        clear;
		logic        en_a;
		logic        en_b;
		logic [15:0] top;
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
	} pwmt_ctl_t;

endpackage

// ===== design/pwmt_div.sv =====
// ----------------------------------------------------------------------------
// pwmt_div
// Restoring divider, one quotient bit per cycle, used for the period end
// computation.
// ----------------------------------------------------------------------------
module pwmt_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [pwmt_pkg::DW-1:0] dividend,
	input  logic [15:0]             divisor,
	output logic                    done,
	output logic [pwmt_pkg::DW-1:0] quot
);

	logic                    run_q;
	logic                    done_q;
	logic [pwmt_pkg::CW-1:0] cnt_q;
	logic [15:0]             rem_q;
	logic [15:0]             dvs_q;
	logic [pwmt_pkg::DW-1:0] quo_q;
	logic [16:0]             trial;
	logic                    ge;
	logic [16:0]             diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[pwmt_pkg::DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pwmt_pkg::CW'(pwmt_pkg::DW);
		end else if (run_q) begin
			cnt_q  <= cnt_q - pwmt_pkg::CW'(1);
			if (cnt_q == pwmt_pkg::CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[pwmt_pkg::DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== design/pwmt_cfg.sv =====
// ----------------------------------------------------------------------------
// pwmt_cfg
// APB register file and the sequencer that derives the period end through
// the divider and the compare values through a reciprocal scale.
// ----------------------------------------------------------------------------
module pwmt_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwmt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output pwmt_pkg::pwmt_ctl_t         ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOP_GO,
		S_TOP_WAIT,
		S_A_MUL,
		S_A_SCL,
		S_B_MUL,
		S_B_SCL
	} seq_state_t;

	seq_state_t              state_q;
	logic [15:0]             freq_q;
	logic [9:0]              duty_a_q;
	logic [9:0]              duty_b_q;
	logic                    en_a_q;
	logic                    en_b_q;
	logic [15:0]             top_q;
	logic [15:0]             cmp_a_q;
	logic [15:0]             cmp_b_q;
	logic [pwmt_pkg::PW-1:0] prod_q;

	logic                    wr;
	logic [2:0]              idx;
	logic [9:0]              duty_wr;
	logic                    recalc;
	logic                    div_start;
	logic [pwmt_pkg::DW-1:0] div_dividend;
	logic [15:0]             div_divisor;
	logic                    div_done;
	logic [pwmt_pkg::DW-1:0] div_quot;
	logic [pwmt_pkg::DW-1:0] q_nz;
	logic [pwmt_pkg::DW-1:0] q_m1;
	logic [15:0]             top_new;
	logic [15:0]             cmp_new;
	logic [pwmt_pkg::PW-1:0] prod_a;
	logic [pwmt_pkg::PW-1:0] prod_b;
	logic [pwmt_pkg::PW-1:0] top_p1;
	logic [pwmt_pkg::SW-1:0] scl_full;
	logic [16:0]             scl_quo;

	assign wr      = psel && penable && pwrite;
	assign idx     = paddr[4:2];
	assign duty_wr = (pwdata[9:0] > pwmt_pkg::DUTY_MAX) ? pwmt_pkg::DUTY_MAX : pwdata[9:0];
	assign recalc  = wr && ((idx == pwmt_pkg::REG_FREQ) || (idx == pwmt_pkg::REG_DUTY_A) ||
		(idx == pwmt_pkg::REG_DUTY_B));

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= pwmt_pkg::RST_FREQ;
			duty_a_q <= '0;
			duty_b_q <= '0;
			en_a_q   <= 1'b0;
			en_b_q   <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				pwmt_pkg::REG_FREQ:   freq_q   <= pwdata[15:0];
				pwmt_pkg::REG_DUTY_A: duty_a_q <= duty_wr;
				pwmt_pkg::REG_DUTY_B: duty_b_q <= duty_wr;
				pwmt_pkg::REG_EN_A:   en_a_q   <= pwdata[0];
				pwmt_pkg::REG_EN_B:   en_b_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			pwmt_pkg::REG_FREQ:   prdata = {16'd0, freq_q};
			pwmt_pkg::REG_DUTY_A: prdata = {22'd0, duty_a_q};
			pwmt_pkg::REG_DUTY_B: prdata = {22'd0, duty_b_q};
			pwmt_pkg::REG_EN_A:   prdata = {31'd0, en_a_q};
			pwmt_pkg::REG_EN_B:   prdata = {31'd0, en_b_q};
			default:              prdata = '0;
		endcase
	end

	// Divider operands: the period division, zero frequency taken as one
	assign div_start    = (state_q == S_TOP_GO);
	assign div_dividend = pwmt_pkg::DW'(pwmt_pkg::DIV_N);
	assign div_divisor  = (freq_q == 16'd0) ? 16'd1 : freq_q;

	pwmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Period end: zero quotient counts as one, minus one, saturate
	assign q_nz    = (div_quot == '0) ? pwmt_pkg::DW'(1) : div_quot;
	assign q_m1    = q_nz - pwmt_pkg::DW'(1);
	assign top_new = (q_m1 > pwmt_pkg::DW'(16'hFFFF)) ? 16'hFFFF : q_m1[15:0];

	// Compare: divide the product by one thousand, clamp to the period end
	assign scl_full = pwmt_pkg::SW'(prod_q) * pwmt_pkg::SW'(pwmt_pkg::RCP_1000);
	assign scl_quo  = scl_full[pwmt_pkg::RCP_SH+16:pwmt_pkg::RCP_SH];
	assign cmp_new  = (scl_quo > {1'b0, top_q}) ? top_q : scl_quo[15:0];

	assign top_p1 = pwmt_pkg::PW'(top_q) + pwmt_pkg::PW'(1);
	assign prod_a = pwmt_pkg::PW'(duty_a_q) * top_p1;
	assign prod_b = pwmt_pkg::PW'(duty_b_q) * top_p1;

	// Recompute sequencer; a new frequency or duty write restarts it from the period division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= pwmt_pkg::RST_TOP;
			cmp_a_q <= '0;
			cmp_b_q <= '0;
			prod_q  <= '0;
		end else if (recalc) begin
			state_q <= S_TOP_GO;
		end else begin
			unique case (state_q)
				S_IDLE:   ;
				S_TOP_GO: state_q <= S_TOP_WAIT;
				S_TOP_WAIT: begin
					if (div_done) begin
						top_q   <= top_new;
						state_q <= S_A_MUL;
					end
				end
				S_A_MUL: begin
					prod_q  <= prod_a;
					state_q <= S_A_SCL;
				end
				S_A_SCL: begin
					cmp_a_q <= cmp_new;
					state_q <= S_B_MUL;
				end
				S_B_MUL: begin
					prod_q  <= prod_b;
					state_q <= S_B_SCL;
				end
				S_B_SCL: begin
					cmp_b_q <= cmp_new;
					state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Control bundle to the counter core
	assign ctl.busy  = (state_q != S_IDLE);
	assign ctl.clear = wr && (idx == pwmt_pkg::REG_FREQ);
	assign ctl.en_a  = en_a_q;
	assign ctl.en_b  = en_b_q;
	assign ctl.top   = top_q;
	assign ctl.cmp_a = cmp_a_q;
	assign ctl.cmp_b = cmp_b_q;

endmodule

// ===== design/pwmt_core.sv =====
// ----------------------------------------------------------------------------
// pwmt_core
// Prescaler, period counter and compare logic with the result register.
// ----------------------------------------------------------------------------
module pwmt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  pwmt_pkg::pwmt_ctl_t ctl,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                tick,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata
);

	logic [2:0]  prescale_q;
	logic [15:0] count_q;
	logic        accept;
	logic [2:0]  ps_n;
	logic [15:0] cnt_n;
	logic        wrap;
	logic        pin_a;
	logic        pin_b;

	// Take a request when no recompute runs and the result register is free or draining
	assign s_tready = !ctl.busy && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Advance prescaler and counter on a tick
	always_comb begin
		ps_n  = prescale_q;
		cnt_n = count_q;
		wrap  = 1'b0;
		if (tick) begin
			if (prescale_q >= pwmt_pkg::PS_LAST) begin
				ps_n = '0;
				if (count_q >= ctl.top) begin
					cnt_n = '0;
					wrap  = 1'b1;
				end else begin
					cnt_n = count_q + 16'd1;
				end
			end else begin
				ps_n = prescale_q + 3'd1;
			end
		end
	end

	// Non-inverting compare
	assign pin_a = ctl.en_a && (cnt_n <= ctl.cmp_a);
	assign pin_b = ctl.en_b && (cnt_n <= ctl.cmp_b);

	// Counter state; a frequency write restarts the period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			count_q    <= '0;
		end else if (ctl.clear) begin
			prescale_q <= '0;
			count_q    <= '0;
		end else if (accept) begin
			prescale_q <= ps_n;
			count_q    <= cnt_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= {5'd0, wrap, cnt_n, pin_b, pin_a};
		end
	end

endmodule

// ===== design/two_channel_fast_pwm_timer_unit.sv =====
// ----------------------------------------------------------------------------
// two_channel_fast_pwm_timer_unit
// 16-bit fast PWM timer with two compare channels and an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one tick request per CPU clock (s_tdata[0]); a
//   zero tick still yields a result but changes no state. Every accepted
//   request yields exactly one result on the m_ channel in the next cycle.
//   Throughput is one request per cycle when no recompute runs: the update
//   and compare are a single pass between the counter and result registers.
//   If the receiver holds m_tready low, the result register holds and
//   s_tready drops until it drains; results are never lost or repeated.
//   A frequency or duty write starts a recompute: a restoring division for
//   the period end (one bit per cycle, DW = 21 bits at the default clock),
//   then a multiply and a reciprocal scale per channel. s_tready stays low
//   from the write until the recompute is done. A frequency write also
//   restarts the prescaler and counter at zero; enable writes act at once.
//   Reset: frequency 1000 Hz (period end 1999), duties and enables zero,
//   counters zero, no result pending.
// ----------------------------------------------------------------------------
module two_channel_fast_pwm_timer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// s_tdata: [0] tick
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	// m_tdata: [0] pin_a, [1] pin_b, [17:2] count_value, [18] period_wrap
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwmt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	pwmt_pkg::pwmt_ctl_t ctl;

	assign pready = 1'b1;

	pwmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.ctl     (ctl)
	);

	pwmt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.tick     (s_tdata[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== design/pwmt_checker.sv =====
// ----------------------------------------------------------------------------
// pwmt_checker
// Port-level assertions for the PWM timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwmt_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [23:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwmt_pkg::ADDR_W-1:0] paddr
);

	logic freq_wr;

	assign freq_wr = psel && penable && pwrite && (paddr[4:2] == pwmt_pkg::REG_FREQ);

	// Stalled result holds
	`PWMT_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A wrap always lands the counter on zero
	`PWMT_ASSERT_IMP(a_wrap_zero, clk, arst_n, m_tvalid && m_tdata[18], m_tdata[17:2] == 16'd0)

	// An idle tick shows up next cycle with no wrap
	`PWMT_ASSERT_NXT(a_idle_tick, clk, arst_n, s_tvalid && s_tready && !s_tdata[0], m_tvalid && !m_tdata[18])

	// A frequency write stalls input while the period is recomputed
	`PWMT_ASSERT_NXT(a_freq_stall, clk, arst_n, freq_wr, !s_tready)

endmodule

bind two_channel_fast_pwm_timer_unit pwmt_checker u_pwmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr)
);

// ===== sim/two_channel_fast_pwm_timer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// two_channel_fast_pwm_timer_unit_tb
// Self-checking bench for the two-channel fast PWM timer. A clocked driver
// sends tick requests from a queue and a clocked monitor takes the results.
// A timer model in the bench predicts every pin, count and wrap flag. The
// APB port is written between phases: at the frequency extremes, at fast
// periods that wrap often, at saturating duties and on unmapped registers.
// ----------------------------------------------------------------------------
module two_channel_fast_pwm_timer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pwmt_pkg::*;

	// Unmapped register indexes, writes there must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	// Recompute time after a register write, with margin
	localparam int SETTLE_CYC = 4 * (DW + 3) + 16;
	localparam int HOLD_CYC   = 80;
	localparam int MAX_PRINT  = 40;

	// One result request as packed on m_tdata
	typedef struct packed {
		logic [4:0]  pad;
		logic        wrap;
		logic [15:0] count;
		logic        pin_b;
		logic        pin_a;
	} pwm_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = 8'd0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [31:0]         pwdata   = 32'd0;
	logic [31:0]         prdata;
	logic                pready;

	// Timer model state and its register copies
	logic [15:0] freq_m;
	logic [9:0]  duty_a_m;
	logic [9:0]  duty_b_m;
	logic        en_a_m;
	logic        en_b_m;
	logic [2:0]  presc_m;
	logic [15:0] count_m;
	logic [15:0] top_m;
	logic [15:0] cmp_a_m;
	logic [15:0] cmp_b_m;

	logic        tick_q[$];
	pwm_result_t due_results[$];

	int          err_cnt   = 0;
	int          tx_wait   = 0;
	int          rx_wait   = 0;
	logic        tx_busy;
	logic        no_idle   = 1'b0;
	logic        hold_req  = 1'b0;
	logic        rx_hold   = 1'b0;
	int          hold_left = 0;
	pwm_result_t seen;
	pwm_result_t want;

	two_channel_fast_pwm_timer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// Period end for a requested frequency, zero taken as one, saturated
	function automatic logic [15:0] period_end_for(input logic [15:0] hz);
		int unsigned div;
		int unsigned quot;
		div = (hz == 16'd0) ? 1 : hz;
		quot = (CPU_HZ / PRESCALE) / div;
		if (quot == 0)
			quot = 1;
		quot = quot - 1;
		if (quot > 65535)
			quot = 65535;
		return quot[15:0];
	endfunction

	// Compare value of one channel, clamped to the period end
	function automatic logic [15:0] compare_for(input logic [9:0] duty, input logic [15:0] top);
		longint unsigned c;
		c = (longint'(duty) * (longint'(top) + 1)) / longint'(DUTY_DIV);
		if (c > top)
			c = top;
		return c[15:0];
	endfunction

	function automatic void refresh_compares();
		cmp_a_m = compare_for(duty_a_m, top_m);
		cmp_b_m = compare_for(duty_b_m, top_m);
	endfunction

	function automatic void model_reset();
		freq_m   = RST_FREQ;
		duty_a_m = '0;
		duty_b_m = '0;
		en_a_m   = 1'b0;
		en_b_m   = 1'b0;
		presc_m  = '0;
		count_m  = '0;
		top_m    = period_end_for(freq_m);
		refresh_compares();
	endfunction

	// Apply one register write to the model
	function automatic void model_write(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			REG_FREQ: begin
				freq_m  = val[15:0];
				top_m   = period_end_for(freq_m);
				presc_m = '0;
				count_m = '0;
				refresh_compares();
			end
			REG_DUTY_A: begin
				duty_a_m = (val[9:0] > DUTY_MAX) ? DUTY_MAX : val[9:0];
				refresh_compares();
			end
			REG_DUTY_B: begin
				duty_b_m = (val[9:0] > DUTY_MAX) ? DUTY_MAX : val[9:0];
				refresh_compares();
			end
			REG_EN_A: en_a_m = val[0];
			REG_EN_B: en_b_m = val[0];
			default: ;
		endcase
	endfunction

	// Step prescaler and counter for one tick request, queue its result
	function automatic void advance_timer(input logic tick);
		pwm_result_t r;
		r = '0;
		if (tick) begin
			if (presc_m == PS_LAST) begin
				presc_m = '0;
				if (count_m >= top_m) begin
					count_m = '0;
					r.wrap  = 1'b1;
				end else begin
					count_m = count_m + 16'd1;
				end
			end else begin
				presc_m = presc_m + 3'd1;
			end
		end
		r.pin_a = en_a_m && (count_m <= cmp_a_m);
		r.pin_b = en_b_m && (count_m <= cmp_b_m);
		r.count = count_m;
		due_results.push_back(r);
	endfunction

	function automatic logic [31:0] with_noise(input logic [31:0] v, input int w);
		logic [31:0] mask;
		mask = 32'hFFFF_FFFF << w;
		return ($urandom() & mask) | (v & ~mask);
	endfunction

	function automatic logic [15:0] pick_fast_hz();
		return 16'($urandom_range(60000, 65535));
	endfunction

	function automatic logic [9:0] pick_duty();
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return DUTY_MAX;
			2: return 10'h3FF;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		err_cnt++;
		if (err_cnt <= MAX_PRINT)
			$display("%0t ns: %s mismatch, got %0h, predicted %0h", $realtime, what, got,
				exp_val);
	endtask

	// APB write: setup, access, then let the recompute finish
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_write(idx, val);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic queue_pattern(input logic [15:0] bits, input int n);
		for (int i = 0; i < n; i++)
			tick_q.push_back(bits[i]);
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: offer tick requests, predict on acceptance, idle between them unless no_idle is set
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			tx_wait = 0;
		end else begin
			tx_busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				advance_timer(s_tdata[0]);
				tx_busy = 1'b0;
				tx_wait = no_idle ? 0 : $urandom_range(0, 6);
			end else if (!s_tvalid && tx_wait > 0) begin
				tx_wait--;
			end
			if (!tx_busy && tx_wait == 0 && tick_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, tick_q.pop_front()};
			end else if (!tx_busy) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: take results, compare with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
				end else begin
					want = due_results.pop_front();
					if (seen.pin_a != want.pin_a)
						report_mismatch("pin_a", 32'(seen.pin_a), 32'(want.pin_a));
					if (seen.pin_b != want.pin_b)
						report_mismatch("pin_b", 32'(seen.pin_b), 32'(want.pin_b));
					if (seen.count != want.count)
						report_mismatch("count_value", 32'(seen.count), 32'(want.count));
					if (seen.wrap != want.wrap)
						report_mismatch("period_wrap", 32'(seen.wrap), 32'(want.wrap));
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 6);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= !rx_hold && (rx_wait == 0);
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req && !rx_hold) begin
			rx_hold   <= 1'b1;
			hold_left <= HOLD_CYC;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else if (rx_hold) begin
			rx_hold   <= 1'b0;
			hold_left <= 0;
		end
	end

	initial begin : stimulus
		int n;
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: both pins disabled, zero ticks hold the state
		queue_pattern(16'b11_1101, 6);
		wait_drained();

		// Zero duty: pins high only while the count is zero
		reg_write(REG_EN_A, with_noise(32'd1, 1));
		reg_write(REG_EN_B, with_noise(32'd1, 1));
		queue_pattern(16'h03FF, 10);
		wait_drained();

		// Full and saturated duty, enable with only bit 1 set, unmapped writes,
		// then the slowest and the fastest period
		reg_write(REG_DUTY_A, with_noise(32'(DUTY_MAX), 10));
		reg_write(REG_DUTY_B, with_noise(32'h3FF, 10));
		reg_write(REG_EN_B, with_noise(32'd2, 2));
		reg_write(REG_SPARE_LO, $urandom());
		reg_write(REG_SPARE_HI, $urandom());
		reg_write(REG_FREQ, with_noise(32'd0, 16));
		queue_pattern(16'b1_1101, 5);
		wait_drained();
		reg_write(REG_FREQ, with_noise(32'hFFFF, 16));
		queue_pattern(16'hF, 4);
		wait_drained();

		// Random phases; the counter keeps running across duty and enable writes
		for (int p = 0; p < 10; p++) begin
			if (p == 0)
				reg_write(REG_FREQ, with_noise(32'(pick_fast_hz()), 16));
			else if (p == 9)
				reg_write(REG_FREQ, with_noise(32'd1, 16));
			reg_write(REG_DUTY_A, with_noise(32'(pick_duty()), 10));
			reg_write(REG_DUTY_B, with_noise(32'(pick_duty()), 10));
			reg_write(REG_EN_A, $urandom());
			reg_write(REG_EN_B, $urandom());
			if ($urandom_range(0, 3) == 0)
				reg_write(3'(REG_SPARE_LO + $urandom_range(0, 2)), $urandom());
			no_idle <= (p % 3 == 1) || (p == 4);
			n = (p == 4) ? 140 : 30 + $urandom_range(0, 20);
			for (int i = 0; i < n; i++)
				tick_q.push_back($urandom_range(0, 19) != 0);
			// Stall the receiver while requests keep coming
			if (p == 4) begin
				hold_req <= 1'b1;
				@(posedge clk iff rx_hold);
				hold_req <= 1'b0;
			end
			wait_drained();
			no_idle <= 1'b0;
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
